### design/tlaik_pkg.sv
// Shared types, constants and tables for the two-link arm jog IK unit.
// No dependencies.
package tlaik_pkg;

	localparam int LINK_LEN_DEF = 60;
	localparam int SAMPLE_W = 12;
	localparam int POS_W = 11;        // signed cursor, covers 2*255+5
	localparam int SQ_W = 21;         // x*x + y*y
	localparam int RAD_W = 18;        // 4*L*L for L up to 255
	localparam int FRAC_SH = 40;      // root operand scale
	localparam int OPND_W = RAD_W + FRAC_SH;
	localparam int ROOT_W = OPND_W / 2;
	localparam int CORD_W = 32;       // CORDIC x/y
	localparam int ZW = 26;           // CORDIC angle accumulator
	localparam int ANG_W = 28;        // Q16 angle working width
	localparam int SQRT_STEPS = ROOT_W;
	localparam int CORDIC_STEPS = 22;
	localparam int CNT_W = 5;
	localparam int OP_SH = 20;        // gamma operand scale
	localparam int ANGLE_GUARD = 128;
	localparam logic signed [ANG_W-1:0] DEG90_Q16 = ANG_W'(90 * 65536);
	localparam logic signed [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);

	// register indexes
	localparam logic [1:0] REG_DEAD_LOW = 2'd0;
	localparam logic [1:0] REG_DEAD_HIGH = 2'd1;
	localparam logic [1:0] REG_FAR_LOW = 2'd2;
	localparam logic [1:0] REG_FAR_HIGH = 2'd3;

	typedef struct packed {
		logic load;
		logic square;
		logic check;
		logic root_init;
		logic root_step;
		logic cord_init;
		logic cord_step;
		logic angle;
		logic commit;
		logic [CNT_W-1:0] idx;
	} tlaik_cmd_t;

	typedef struct packed {
		logic go;
	} tlaik_stat_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic [ZW-1:0] atan_entry(input logic [CNT_W-1:0] i);
		logic [ZW-1:0] v;
		unique case (i)
			5'd0: v = ZW'(2949120);
			5'd1: v = ZW'(1740967);
			5'd2: v = ZW'(919879);
			5'd3: v = ZW'(466945);
			5'd4: v = ZW'(234379);
			5'd5: v = ZW'(117304);
			5'd6: v = ZW'(58666);
			5'd7: v = ZW'(29335);
			5'd8: v = ZW'(14668);
			5'd9: v = ZW'(7334);
			5'd10: v = ZW'(3667);
			5'd11: v = ZW'(1833);
			5'd12: v = ZW'(917);
			5'd13: v = ZW'(458);
			5'd14: v = ZW'(229);
			5'd15: v = ZW'(115);
			5'd16: v = ZW'(57);
			5'd17: v = ZW'(29);
			5'd18: v = ZW'(14);
			5'd19: v = ZW'(7);
			5'd20: v = ZW'(4);
			5'd21: v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### design/tlaik_sqrt.sv
// Bit-serial floor integer square root, two operand bits per cycle while step is high.
// Depends on tlaik_pkg.
module tlaik_sqrt
	import tlaik_pkg::*;
(
	input  logic              clk,
	input  logic              init,
	input  logic              step,
	input  logic [OPND_W-1:0] opnd,
	output logic [ROOT_W-1:0] root
);

	logic [OPND_W-1:0] opnd_q;
	logic [31:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [33:0] cur;
	logic [33:0] trial;

	assign cur = {rem_q, opnd_q[OPND_W-1 -: 2]};
	assign trial = {3'b000, root_q, 2'b01};

	// one restoring digit per step
	always_ff @(posedge clk) begin
		if (init) begin
			opnd_q <= opnd;
			rem_q <= '0;
			root_q <= '0;
		end else if (step) begin
			opnd_q <= {opnd_q[OPND_W-3:0], 2'b00};
			if (cur >= trial) begin
				rem_q <= 32'(cur - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= cur[31:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;

endmodule

### design/tlaik_cordic.sv
// CORDIC vectoring unit, one rotation per cycle while step is high, angle in Q16 degrees.
// Depends on tlaik_pkg.
module tlaik_cordic
	import tlaik_pkg::*;
(
	input  logic                     clk,
	input  logic                     init,
	input  logic                     step,
	input  logic [CNT_W-1:0]         idx,
	input  logic signed [CORD_W-1:0] x0,
	input  logic signed [CORD_W-1:0] y0,
	output logic signed [ZW-1:0]     z
);

	logic signed [CORD_W-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CORD_W-1:0] xs, ys;
	logic signed [ZW-1:0] a;

	assign xs = x_q >>> idx;
	assign ys = y_q >>> idx;
	assign a = signed'(atan_entry(idx));

	// drive y toward zero
	always_ff @(posedge clk) begin
		if (init) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (step) begin
			if (!y_q[CORD_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end
		end
	end

	assign z = z_q;

endmodule

### design/tlaik_dp.sv
// Datapath: thresholds, cursor and angle state, roots, CORDIC, angle assembly.
// Depends on tlaik_pkg, tlaik_sqrt, tlaik_cordic.
module tlaik_dp
	import tlaik_pkg::*;
#(
	parameter int LINK_LEN = LINK_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic [SAMPLE_W-1:0] horiz_sample,
	input  logic [SAMPLE_W-1:0] vert_sample,
	input  tlaik_cmd_t          cmd,
	output tlaik_stat_t         stat,
	output logic [7:0]          shoulder_deg,
	output logic [7:0]          elbow_deg,
	output logic                shoulder_moved,
	output logic                elbow_moved,
	output logic                reachable,
	output logic [7:0]          cursor_x,
	output logic [6:0]          cursor_y
);

	localparam logic [RAD_W-1:0] REACH2 = RAD_W'(4 * LINK_LEN * LINK_LEN);

	logic [11:0] dead_low_q, dead_high_q, far_low_q, far_high_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, tx_q, ty_q;
	logic [7:0] sh_now_q, el_now_q;
	logic dead_q, go_q, reach_q;
	logic [SQ_W-1:0] sqx_q, sqy_q, r2_q;
	logic [7:0] nsh_q, nel_q;
	logic signed [3:0] dx, dy;
	logic signed [2*POS_W-1:0] px, py;
	logic [SQ_W-1:0] r2;
	logic reach_ok;
	logic [ROOT_W-1:0] root_c, root_s;
	logic [RAD_W-1:0] diff;
	logic signed [ZW-1:0] za, zg;
	logic signed [POS_W-1:0] ax;
	logic signed [ANG_W-1:0] alpha, graw, gamma, sh, el;

	function automatic logic signed [3:0] axis_step(input logic [11:0] s,
			input logic [11:0] dl, input logic [11:0] dh,
			input logic [11:0] fl, input logic [11:0] fh);
		logic signed [3:0] v;
		priority if (s < dl) v = (s < fl) ? -4'sd5 : -4'sd1;
		else if (s > dh) v = (s > fh) ? 4'sd5 : 4'sd1;
		else v = 4'sd0;
		return v;
	endfunction

	function automatic logic [7:0] to_deg(input logic signed [ANG_W-1:0] q);
		logic signed [ANG_W-1:0] g;
		logic [7:0] d;
		g = q + ANG_W'(ANGLE_GUARD);
		priority if (g < 0) d = 8'd0;
		else if (g > DEG180_Q16) d = 8'd180;
		else d = g[23:16];
		return d;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_low_q <= 12'd1884;
			dead_high_q <= 12'd2212;
			far_low_q <= 12'd164;
			far_high_q <= 12'd3850;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEAD_LOW: dead_low_q <= cfg_data;
				REG_DEAD_HIGH: dead_high_q <= cfg_data;
				REG_FAR_LOW: far_low_q <= cfg_data;
				REG_FAR_HIGH: far_high_q <= cfg_data;
			endcase
		end
	end

	assign dx = axis_step(horiz_sample, dead_low_q, dead_high_q, far_low_q, far_high_q);
	assign dy = axis_step(vert_sample, dead_low_q, dead_high_q, far_low_q, far_high_q);
	assign px = tx_q * tx_q;
	assign py = ty_q * ty_q;
	assign r2 = sqx_q + sqy_q;
	assign reach_ok = !ty_q[POS_W-1] && (r2 <= SQ_W'(REACH2));
	assign diff = REACH2 - r2_q[RAD_W-1:0];
	assign ax = tx_q[POS_W-1] ? -tx_q : tx_q;

	// target, squares and reach check
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q <= pos_x_q + POS_W'(dx);
			ty_q <= pos_y_q + POS_W'(dy);
			dead_q <= (dx == 4'sd0) && (dy == 4'sd0);
		end
		if (cmd.square) begin
			sqx_q <= SQ_W'(px);
			sqy_q <= SQ_W'(py);
		end
		if (cmd.check) begin
			r2_q <= r2;
			go_q <= !dead_q && reach_ok;
			reach_q <= dead_q || reach_ok;
		end
	end

	assign stat.go = go_q;

	tlaik_sqrt u_sqrt_c (
		.clk  (clk),
		.init (cmd.root_init),
		.step (cmd.root_step),
		.opnd ({r2_q[RAD_W-1:0], {FRAC_SH{1'b0}}}),
		.root (root_c)
	);

	tlaik_sqrt u_sqrt_s (
		.clk  (clk),
		.init (cmd.root_init),
		.step (cmd.root_step),
		.opnd ({diff, {FRAC_SH{1'b0}}}),
		.root (root_s)
	);

	tlaik_cordic u_cord_a (
		.clk  (clk),
		.init (cmd.cord_init),
		.step (cmd.cord_step),
		.idx  (cmd.idx),
		.x0   (signed'(CORD_W'(root_c))),
		.y0   (signed'(CORD_W'(root_s))),
		.z    (za)
	);

	tlaik_cordic u_cord_g (
		.clk  (clk),
		.init (cmd.cord_init),
		.step (cmd.cord_step),
		.idx  (cmd.idx),
		.x0   (CORD_W'(ax) <<< OP_SH),
		.y0   (CORD_W'(ty_q) <<< OP_SH),
		.z    (zg)
	);

	// angle assembly with the exact axis cases
	always_comb begin
		priority if (root_s == '0) alpha = '0;
		else if (root_c == '0) alpha = DEG90_Q16;
		else alpha = ANG_W'(za);
		priority if (ty_q == '0) graw = '0;
		else if (tx_q == '0) graw = DEG90_Q16;
		else graw = ANG_W'(zg);
		gamma = tx_q[POS_W-1] ? DEG180_Q16 - graw : graw;
		if (!tx_q[POS_W-1] && tx_q != '0) begin
			sh = gamma + alpha;
			el = DEG90_Q16 - (alpha <<< 1);
		end else begin
			sh = gamma - alpha;
			el = DEG90_Q16 + (alpha <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.angle) begin
			nsh_q <= to_deg(sh);
			nel_q <= to_deg(el);
		end
	end

	// arm state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= POS_W'(2 * LINK_LEN);
			sh_now_q <= 8'd90;
			el_now_q <= 8'd90;
		end else if (cmd.commit && go_q) begin
			pos_x_q <= tx_q;
			pos_y_q <= ty_q;
			sh_now_q <= nsh_q;
			el_now_q <= nel_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			reachable <= reach_q;
			if (go_q) begin
				shoulder_deg <= nsh_q;
				elbow_deg <= nel_q;
				shoulder_moved <= nsh_q != sh_now_q;
				elbow_moved <= nel_q != el_now_q;
				cursor_x <= tx_q[7:0];
				cursor_y <= ty_q[6:0];
			end else begin
				shoulder_deg <= sh_now_q;
				elbow_deg <= el_now_q;
				shoulder_moved <= 1'b0;
				elbow_moved <= 1'b0;
				cursor_x <= pos_x_q[7:0];
				cursor_y <= pos_y_q[6:0];
			end
		end
	end

endmodule

### design/tlaik_ctrl.sv
// Controller: sequences one item through the datapath, holds output valid.
// Depends on tlaik_pkg.
module tlaik_ctrl
	import tlaik_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  tlaik_stat_t stat,
	output tlaik_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SQ    = 9'b000000010,
		S_CHK   = 9'b000000100,
		S_INIT  = 9'b000001000,
		S_ROOT  = 9'b000010000,
		S_CINIT = 9'b000100000,
		S_CORD  = 9'b001000000,
		S_ANG   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_free, commit;

	assign out_free = !m_tvalid || m_tready;
	assign commit = (state_q == S_FIN) && out_free;
	assign s_tready = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_SQ;
			S_SQ: state_d = S_CHK;
			S_CHK: state_d = S_INIT;
			S_INIT: state_d = stat.go ? S_ROOT : S_FIN;
			S_ROOT: if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_CINIT;
			S_CINIT: state_d = S_CORD;
			S_CORD: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = S_ANG;
			S_ANG: state_d = S_FIN;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ROOT || state_q == S_CORD) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (commit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// datapath commands
	always_comb begin
		cmd.load = (state_q == S_IDLE) && s_tvalid;
		cmd.square = (state_q == S_SQ);
		cmd.check = (state_q == S_CHK);
		cmd.root_init = (state_q == S_INIT);
		cmd.root_step = (state_q == S_ROOT);
		cmd.cord_init = (state_q == S_CINIT);
		cmd.cord_step = (state_q == S_CORD);
		cmd.angle = (state_q == S_ANG);
		cmd.commit = commit;
		cmd.idx = cnt_q;
	end

endmodule

### design/two_link_arm_jog_inverse_kinematics_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   24     horiz_sample, vert_sample
// m_axis    out  40     angles, moved flags, reachable, cursor
// cfg       in   12     threshold registers 0..3
//
// From accept to result valid, a moving item runs two 29-step
// square roots side by side, then two 22-step CORDIC units side by side.
// An item in the dead zone or out of reach skips the roots and the CORDIC units.
// The next item can be taken in the cycle after the result is committed.
// One item is in work at a time; a new item is taken while a result waits.
// A stalled result holds the last step; reset restores cursor and angles.
// Top level: joins controller and datapath. Depends on tlaik_pkg, tlaik_ctrl, tlaik_dp.
module two_link_arm_jog_inverse_kinematics_unit
	import tlaik_pkg::*;
#(
	parameter int LINK_LEN = LINK_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // horiz_sample[11:0], vert_sample[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // shoulder_deg[7:0], elbow_deg[15:8],
	                               // shoulder_moved[16], elbow_moved[17],
	                               // reachable[18], cursor_x[26:19],
	                               // cursor_y[33:27], zero[39:34]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	tlaik_cmd_t cmd;
	tlaik_stat_t stat;
	logic [7:0] shoulder_deg, elbow_deg, cursor_x;
	logic [6:0] cursor_y;
	logic shoulder_moved, elbow_moved, reachable;

	tlaik_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlaik_dp #(.LINK_LEN(LINK_LEN)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.horiz_sample   (s_tdata[11:0]),
		.vert_sample    (s_tdata[23:12]),
		.cmd            (cmd),
		.stat           (stat),
		.shoulder_deg   (shoulder_deg),
		.elbow_deg      (elbow_deg),
		.shoulder_moved (shoulder_moved),
		.elbow_moved    (elbow_moved),
		.reachable      (reachable),
		.cursor_x       (cursor_x),
		.cursor_y       (cursor_y)
	);

	assign m_tdata = {6'b000000, cursor_y, cursor_x, reachable, elbow_moved,
		shoulder_moved, elbow_deg, shoulder_deg};

endmodule

### sim/tb_two_link_arm_jog_inverse_kinematics_unit.sv
// Testbench for the two-link arm jog IK unit: joystick items in, angle/cursor items out.
// The expected angles and cursor come from a predictor in this file. Depends on tlaik_pkg
// and the top module.
`timescale 1ns / 1ps

module tb_two_link_arm_jog_inverse_kinematics_unit;
	import tlaik_pkg::*;

	localparam int ARM_LEN = 60;

	typedef struct packed {
		logic [6:0]  cy;
		logic [7:0]  cx;
		logic        reach;
		logic        el_mv;
		logic        sh_mv;
		logic [7:0]  elbow;
		logic [7:0]  shoulder;
	} pose_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DEAD_LOW;
	logic [11:0] cfg_data = '0;

	// predictor state
	logic [11:0] thr_dead_lo, thr_dead_hi, thr_far_lo, thr_far_hi;
	int pen_x, pen_y, sh_deg, el_deg;
	pose_t pose_q[$];
	int errors = 0;
	bit hold_off = 1'b0;
	bit bursty = 1'b1;

	two_link_arm_jog_inverse_kinematics_unit #(.LINK_LEN(ARM_LEN)) u_top (.*);

	always #5 clk = ~clk;

	localparam longint ATAN_Q16 [22] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// vectoring CORDIC, first quadrant, Q16 degrees
	function automatic longint cordic_atan(longint y, longint x);
		longint z, nx, ny;
		z = 0;
		if (y == 0) return 0;
		if (x == 0) return 90 * 65536;
		for (int i = 0; i < 22; i++) begin
			if (y >= 0) begin
				nx = x + floor_shr(y, i);
				ny = y - floor_shr(x, i);
				z += ATAN_Q16[i];
			end else begin
				nx = x - floor_shr(y, i);
				ny = y + floor_shr(x, i);
				z -= ATAN_Q16[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic int jog_step(logic [11:0] s);
		if (s < thr_dead_lo) return (s < thr_far_lo) ? -5 : -1;
		if (s > thr_dead_hi) return (s > thr_far_hi) ? 5 : 1;
		return 0;
	endfunction

	function automatic int q16_to_deg(longint q);
		q += ANGLE_GUARD;
		if (q < 0) q = 0;
		if (q > 180 * 65536) q = 180 * 65536;
		return int'(q / 65536);
	endfunction

	// work out the pose after one joystick item and update predictor state
	function automatic pose_t jog_pose(logic [11:0] hs, logic [11:0] vs);
		int dx, dy, nsh, nel;
		longint tx, ty, r2, lim, c, s, alpha, gamma, sh, el;
		pose_t p;
		dx = jog_step(hs);
		dy = jog_step(vs);
		p = '0;
		p.reach = 1'b1;
		if (dx != 0 || dy != 0) begin
			tx = pen_x + dx;
			ty = pen_y + dy;
			r2 = tx * tx + ty * ty;
			lim = 4 * ARM_LEN * ARM_LEN;
			if (ty < 0 || r2 > lim) begin
				p.reach = 1'b0;
			end else begin
				c = int_sqrt(longint'(r2) << 40);
				s = int_sqrt(longint'(lim - r2) << 40);
				alpha = cordic_atan(s, c);
				gamma = cordic_atan(ty << 20, (tx < 0 ? -tx : tx) << 20);
				if (tx < 0) gamma = 180 * 65536 - gamma;
				if (tx > 0) begin
					sh = gamma + alpha;
					el = 90 * 65536 - 2 * alpha;
				end else begin
					sh = gamma - alpha;
					el = 90 * 65536 + 2 * alpha;
				end
				nsh = q16_to_deg(sh);
				nel = q16_to_deg(el);
				pen_x = int'(tx);
				pen_y = int'(ty);
				p.sh_mv = nsh != sh_deg;
				p.el_mv = nel != el_deg;
				sh_deg = nsh;
				el_deg = nel;
			end
		end
		p.shoulder = sh_deg[7:0];
		p.elbow = el_deg[7:0];
		p.cx = pen_x[7:0];
		p.cy = pen_y[6:0];
		return p;
	endfunction

	// send one joystick item, with a random gap in bursty mode;
	// valid stays up after the accept until the next gap or drain
	task automatic send_jog(logic [11:0] hs, logic [11:0] vs);
		if (bursty && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vs, hs};
		pose_q.push_back(jog_pose(hs, vs));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DEAD_LOW:  thr_dead_lo = val;
			REG_DEAD_HIGH: thr_dead_hi = val;
			REG_FAR_LOW:   thr_far_lo = val;
			default:       thr_far_hi = val;
		endcase
	endtask

	// a sample inside a band chosen at random across the thresholds
	function automatic logic [11:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 12'($urandom_range(0, 4095));
			1: return 12'($urandom_range(0, 163));
			2: return 12'($urandom_range(3851, 4095));
			3: return 12'($urandom_range(164, 1883));
			4: return 12'($urandom_range(2213, 3849));
			default: return 12'($urandom_range(1884, 2212));
		endcase
	endfunction

	task automatic test_directed();
		send_jog(12'd2000, 12'd2000);        // dead zone both
		send_jog(12'd2000, 12'd4095);        // off the top: unreachable
		send_jog(12'd0, 12'd2000);           // far left
		send_jog(12'd4095, 12'd2000);        // far right back
		send_jog(12'd1000, 12'd2000);
		send_jog(12'd3000, 12'd2000);
		send_jog(12'd2000, 12'd1000);
		send_jog(12'd2000, 12'd3000);
		send_jog(12'd1884, 12'd2212);        // threshold edges: dead
		send_jog(12'd1883, 12'd2213);
		send_jog(12'd164, 12'd3850);
		send_jog(12'd163, 12'd3851);
		send_jog(12'hAAA, 12'h555);
		send_jog(12'h555, 12'hAAA);
		// dive to origin and below
		repeat (26) send_jog(12'd2000, 12'd0);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_jog(rand_sample(), rand_sample());
		drain();
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		bursty = 1'b0;
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_jog(rand_sample(), rand_sample());
		join
		bursty = 1'b1;
		drain();
	endtask

	task automatic test_thresholds();
		write_reg(REG_DEAD_LOW, 12'd0);
		write_reg(REG_DEAD_HIGH, 12'd4095);
		write_reg(REG_FAR_LOW, 12'd0);
		write_reg(REG_FAR_HIGH, 12'd4095);
		test_random(30);                      // always dead
		write_reg(REG_DEAD_LOW, 12'd4095);
		write_reg(REG_DEAD_HIGH, 12'd0);
		write_reg(REG_FAR_LOW, 12'd2048);
		write_reg(REG_FAR_HIGH, 12'd2048);
		test_random(300);                     // out of order
		write_reg(REG_DEAD_LOW, 12'd2000);
		write_reg(REG_DEAD_HIGH, 12'd2100);
		write_reg(REG_FAR_LOW, 12'd1000);
		write_reg(REG_FAR_HIGH, 12'd3000);
		test_random(400);
		write_reg(REG_DEAD_LOW, 12'd1884);
		write_reg(REG_DEAD_HIGH, 12'd2212);
		write_reg(REG_FAR_LOW, 12'd164);
		write_reg(REG_FAR_HIGH, 12'd3850);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else if ($urandom_range(0, 99) < 15 && pose_q.size() % 3 != 0) m_tready <= 1'b0;
		else m_tready <= 1'b1;
	end

	// result check
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = pose_q.pop_front();
				if (got !== want || m_tdata[39:34] !== 6'd0) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, m_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		thr_dead_lo = 12'd1884;
		thr_dead_hi = 12'd2212;
		thr_far_lo = 12'd164;
		thr_far_hi = 12'd3850;
		pen_x = 0;
		pen_y = 2 * ARM_LEN;
		sh_deg = 90;
		el_deg = 90;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_thresholds();
		test_random(1250);
		if (errors == 0 && pose_q.size() == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
